// File: rtl/pba_pkg.sv
// Shared types, codes and constants of the page bitmap allocator.
package pba_pkg;

  localparam int NUM_PAGES_DEF = 65536;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;
  localparam int OFF_W         = 6;
  localparam int CMD_W         = 2;
  localparam int PAGE_W        = 16;
  localparam int LEN_W         = 17;
  localparam int CNT_W         = 17;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  localparam logic [LEN_W-1:0] PAGE_COUNT_RST = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_QUERY   = 2'd3
  } pba_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NORUN = 2'd1,
    STAT_RANGE = 2'd2
  } pba_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RCINIT,
    S_RECOUNT,
    S_SCAN,
    S_UPSET,
    S_UPDATE,
    S_QUERY,
    S_DONE
  } pba_state_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] hit_end;
    logic [OFF_W-1:0] pre_free;
    logic [OFF_W-1:0] lead_free;
  } pba_scan_t;

endpackage

// File: rtl/pba_word_unit.sv
// Shared bitmap word unit: free-run search, run update mask and bit count.
module pba_word_unit
  import pba_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  input  logic [OFF_W-1:0]  valid_off_i,
  input  logic [OFF_W-1:0]  lo_off_i,
  input  logic [OFF_W-1:0]  hi_off_i,
  input  logic [OFF_W-1:0]  run_len_i,
  input  logic              set_i,
  output pba_scan_t         scan_o,
  output logic [WORD_W-1:0] word_o,
  output logic [OFF_W-1:0]  chg_cnt_o
);

  logic [WORD_W-1:0] free_w;
  logic [WORD_W-1:0] umask;
  logic [WORD_W-1:0] chg;
  logic [WORD_W-1:0] runs [OFF_W];
  logic [WORD_W-1:0] acc;
  logic              acc_empty;

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      free_w[k] = !word_i[k] && (OFF_W'(k) < valid_off_i);
      umask[k]  = (OFF_W'(k) >= lo_off_i) && (OFF_W'(k) < hi_off_i);
    end
  end

  // runs[b][j]: pages j-2^b+1 .. j of this word are all free
  always_comb begin
    runs[0] = free_w;
    for (int b = 1; b < OFF_W; b++) begin
      runs[b] = runs[b-1] & (runs[b-1] << (1 << (b-1)));
    end
  end

  always_comb begin
    acc       = '1;
    acc_empty = 1'b1;
    for (int b = 0; b < OFF_W; b++) begin
      if (run_len_i[b]) begin
        if (acc_empty) begin
          acc = runs[b];
        end else begin
          acc = runs[b] & (acc << (1 << b));
        end
        acc_empty = 1'b0;
      end
    end
  end

  always_comb begin
    scan_o.hit       = !acc_empty && (|acc);
    scan_o.hit_end   = '0;
    scan_o.pre_free  = OFF_W'(WORD_W);
    scan_o.lead_free = OFF_W'(WORD_W);
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (acc[k]) begin
        scan_o.hit_end = BIT_W'(k);
      end
      if (!free_w[k]) begin
        scan_o.pre_free = OFF_W'(k);
      end
    end
    for (int k = 0; k < WORD_W; k++) begin
      if (!free_w[k]) begin
        scan_o.lead_free = OFF_W'(WORD_W - 1 - k);
      end
    end
  end

  assign chg       = set_i ? (umask & ~word_i) : (umask & word_i);
  assign word_o    = set_i ? (word_i | umask) : (word_i & ~umask);
  assign chg_cnt_o = OFF_W'($countones(chg));

endmodule

// File: rtl/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
//  channel  dir  handshake          payload
//  in_      in   in_tvalid/tready   tuser: cmd; tdata: start_page, run_pages
//  out_     out  out_tvalid/tready  tdata: status, first_page, page_is_used, used_count
//  cfg_     in   cfg_wen            cfg_wdata: page_count
//
// One 32-page bitmap word per cycle goes through the shared word unit; N = ceil(active pages/32).
// A zero-length allocate, an allocate on an empty map and an out-of-range query go straight to
// the result; a failed allocate reads all N words, a fitting one stops at the word ending
// the run and writes its pages; free and reserve write only the words in range.
// Reset runs a clearing pass over all MAP_WORDS words (2048 by default) with in_tready low; a
// page_count write holds in_tready low while the used pages are recounted.
// A finished result waits in the output register while out_tready is low.
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // start_page[15:0], run_pages[32:16]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[1:0], first_page[17:2],
                                             // page_is_used[18], used_count[35:19]
  input  logic                   cfg_wen,
  input  logic [LEN_W-1:0]       cfg_wdata   // page_count
);

  localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW        = $clog2(MAP_WORDS);
  localparam int LIM_W     = $clog2(NUM_PAGES + 1);
  localparam int IDX_W     = (LIM_W > LEN_W) ? LIM_W : LEN_W;
  localparam int WC_W      = IDX_W - BIT_W + 1;
  localparam int PAD_W     = OUT_TDATA_W - CNT_W - 1 - PAGE_W - 2;

  function automatic logic [OFF_W-1:0] word_off(input logic [IDX_W:0] x,
                                                input logic [IDX_W:0] b);
    logic [IDX_W:0] d;
    d = x - b;
    if (x <= b) return '0;
    if (d >= (IDX_W+1)'(WORD_W)) return OFF_W'(WORD_W);
    return d[OFF_W-1:0];
  endfunction

  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  pba_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  page_count_r, page_count_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  pba_cmd_t          cmd_r, cmd_nxt;
  logic [PAGE_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  found_r, found_nxt;
  logic [IDX_W-1:0]  run_r, run_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [WC_W-1:0]   rd_w_r, rd_w_nxt;
  logic [WC_W-1:0]   end_w_r, end_w_nxt;
  logic [WC_W-1:0]   pend_w_r, pend_w_nxt;
  logic              pend_r, pend_nxt;
  pba_status_t       res_status_r, res_status_nxt;
  logic [PAGE_W-1:0] res_first_r, res_first_nxt;
  logic              res_qbit_r, res_qbit_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [IDX_W-1:0]  lim;
  logic [IDX_W-1:0]  lim_m1;
  logic [WC_W-1:0]   lim_end_w;
  logic [IDX_W:0]    base;
  logic [IDX_W-1:0]  base_i;
  logic              sweeping;
  logic              rd_en;
  logic              last_word;
  logic              in_acc;
  pba_cmd_t          in_cmd;
  logic [PAGE_W-1:0] in_start;
  logic [LEN_W-1:0]  in_len;
  logic [IDX_W-1:0]  start_x;
  logic              q_range;
  logic              alloc_none;

  logic [OFF_W-1:0]  u_valid_off, u_lo_off, u_hi_off, u_run_len;
  logic              u_set;
  pba_scan_t         scan;
  logic [WORD_W-1:0] u_word;
  logic [OFF_W-1:0]  u_chg_cnt;

  logic [IDX_W:0]    pre_sum;
  logic              hit_a, hit_b, scan_hit, start_fits, all_free;
  logic [IDX_W-1:0]  start_a, start_b, start_hit;
  logic [IDX_W-1:0]  found_more, run_more, run_tail;

  logic [IDX_W:0]    up_sum;
  logic [IDX_W-1:0]  up_hi, up_hi_m1;
  logic              up_empty;

  assign lim       = ({{(IDX_W-LEN_W){1'b0}}, page_count_r} > IDX_W'(NUM_PAGES)) ?
                     IDX_W'(NUM_PAGES) : IDX_W'(page_count_r);
  assign lim_m1    = lim - IDX_W'(1);
  assign lim_end_w = WC_W'(lim_m1[IDX_W-1:BIT_W]);
  assign base      = {pend_w_r, {BIT_W{1'b0}}};
  assign base_i    = base[IDX_W-1:0];

  assign sweeping  = (state_r == S_RECOUNT) || (state_r == S_SCAN) ||
                     (state_r == S_UPDATE)  || (state_r == S_QUERY);
  assign rd_en     = sweeping && (rd_w_r <= end_w_r);
  assign last_word = pend_r && (pend_w_r == end_w_r);

  assign in_tready  = (state_r == S_IDLE) && !cfg_wen;
  assign in_acc     = in_tvalid && in_tready;
  assign in_cmd     = pba_cmd_t'(in_tuser);
  assign in_start   = in_tdata[PAGE_W-1:0];
  assign in_len     = in_tdata[PAGE_W+LEN_W-1:PAGE_W];
  assign start_x    = IDX_W'(in_start);
  assign q_range    = start_x >= lim;
  assign alloc_none = (in_len == '0) || (lim == '0);

  always_comb begin
    u_valid_off = word_off({1'b0, lim}, base);
    u_lo_off    = '0;
    u_hi_off    = '0;
    u_set       = 1'b0;
    u_run_len   = (len_r <= LEN_W'(WORD_W)) ? OFF_W'(len_r) : '0;
    if (state_r == S_UPDATE) begin
      u_lo_off = word_off({1'b0, lo_r}, base);
      u_hi_off = word_off({1'b0, hi_r}, base);
      u_set    = (cmd_r != CMD_FREE);
    end else if (state_r == S_RECOUNT) begin
      u_hi_off = u_valid_off;
    end
  end

  pba_word_unit u_word_unit (
    .word_i      (mem_q_r),
    .valid_off_i (u_valid_off),
    .lo_off_i    (u_lo_off),
    .hi_off_i    (u_hi_off),
    .run_len_i   (u_run_len),
    .set_i       (u_set),
    .scan_o      (scan),
    .word_o      (u_word),
    .chg_cnt_o   (u_chg_cnt)
  );

  assign pre_sum    = {1'b0, found_r} + (IDX_W+1)'(scan.pre_free);
  assign hit_a      = pre_sum >= (IDX_W+1)'(len_r);
  assign hit_b      = (len_r <= LEN_W'(WORD_W)) && scan.hit;
  assign start_a    = (found_r == '0) ? base_i : run_r;
  assign start_b    = base_i + IDX_W'(scan.hit_end) + IDX_W'(1) - IDX_W'(len_r);
  assign scan_hit   = hit_a || hit_b;
  assign start_hit  = hit_a ? start_a : start_b;
  assign start_fits = (start_hit[IDX_W-1:PAGE_W] == '0);
  assign all_free   = (scan.pre_free == OFF_W'(WORD_W));
  assign found_more = found_r + IDX_W'(WORD_W);
  assign run_more   = (found_r == '0) ? base_i : run_r;
  assign run_tail   = base_i + IDX_W'(WORD_W) - IDX_W'(scan.lead_free);

  assign up_sum   = {1'b0, lo_r} + (IDX_W+1)'(len_r);
  assign up_hi    = (up_sum > {1'b0, lim}) ? lim : up_sum[IDX_W-1:0];
  assign up_empty = (up_hi <= lo_r);
  assign up_hi_m1 = up_hi - IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (rd_w_r == WC_W'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_wen) begin
          state_nxt = S_RCINIT;
        end else if (in_acc) begin
          unique case (in_cmd) inside
            CMD_ALLOC:            state_nxt = alloc_none ? S_DONE : S_SCAN;
            CMD_FREE, CMD_RESERVE: state_nxt = S_UPSET;
            CMD_QUERY:            state_nxt = q_range ? S_DONE : S_QUERY;
          endcase
        end
      end
      S_RCINIT: begin
        if (!cfg_wen) state_nxt = (lim == '0) ? S_IDLE : S_RECOUNT;
      end
      S_RECOUNT: begin
        if (cfg_wen) begin
          state_nxt = S_RCINIT;
        end else if (last_word) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (pend_r && scan_hit) begin
          state_nxt = start_fits ? S_UPSET : S_DONE;
        end else if (last_word) begin
          state_nxt = S_DONE;
        end
      end
      S_UPSET: begin
        state_nxt = up_empty ? S_DONE : S_UPDATE;
      end
      S_UPDATE: begin
        if (last_word) state_nxt = S_DONE;
      end
      S_QUERY: begin
        if (pend_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    page_count_nxt = page_count_r;
    used_nxt       = used_r;
    cmd_nxt        = cmd_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    found_nxt      = found_r;
    run_nxt        = run_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rd_w_nxt       = rd_w_r;
    end_w_nxt      = end_w_r;
    pend_w_nxt     = rd_w_r;
    pend_nxt       = rd_en;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_qbit_nxt   = res_qbit_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = pend_w_r[AW-1:0];
    mem_wdata      = u_word;

    if (cfg_wen) page_count_nxt = cfg_wdata;
    if (rd_en) rd_w_nxt = rd_w_r + WC_W'(1);
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_w_r[AW-1:0];
        mem_wdata = '0;
        rd_w_nxt  = rd_w_r + WC_W'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_cmd;
          start_nxt      = in_start;
          len_nxt        = in_len;
          lo_nxt         = start_x;
          res_status_nxt = STAT_OK;
          res_first_nxt  = '0;
          res_qbit_nxt   = 1'b0;
          unique case (in_cmd) inside
            CMD_ALLOC: begin
              found_nxt = '0;
              run_nxt   = '0;
              rd_w_nxt  = '0;
              end_w_nxt = lim_end_w;
              if (alloc_none) res_status_nxt = STAT_NORUN;
            end
            CMD_FREE, CMD_RESERVE: begin
            end
            CMD_QUERY: begin
              rd_w_nxt  = WC_W'(start_x[IDX_W-1:BIT_W]);
              end_w_nxt = WC_W'(start_x[IDX_W-1:BIT_W]);
              if (q_range) res_status_nxt = STAT_RANGE;
            end
          endcase
        end
      end
      S_RCINIT: begin
        used_nxt  = '0;
        rd_w_nxt  = '0;
        end_w_nxt = lim_end_w;
      end
      S_RECOUNT: begin
        if (pend_r) used_nxt = used_r + CNT_W'(u_chg_cnt);
      end
      S_SCAN: begin
        if (pend_r) begin
          if (scan_hit) begin
            lo_nxt = start_hit;
            if (start_fits) begin
              res_first_nxt = start_hit[PAGE_W-1:0];
            end else begin
              res_status_nxt = STAT_NORUN;
            end
          end else begin
            if (all_free) begin
              found_nxt = found_more;
              run_nxt   = run_more;
            end else begin
              found_nxt = IDX_W'(scan.lead_free);
              run_nxt   = run_tail;
            end
            if (last_word) res_status_nxt = STAT_NORUN;
          end
        end
      end
      S_UPSET: begin
        hi_nxt    = up_hi;
        rd_w_nxt  = WC_W'(lo_r[IDX_W-1:BIT_W]);
        end_w_nxt = WC_W'(up_hi_m1[IDX_W-1:BIT_W]);
      end
      S_UPDATE: begin
        if (pend_r) begin
          mem_we = 1'b1;
          if (cmd_r != CMD_FREE) begin
            used_nxt = used_r + CNT_W'(u_chg_cnt);
          end else begin
            used_nxt = used_r - CNT_W'(u_chg_cnt);
          end
        end
      end
      S_QUERY: begin
        if (pend_r) res_qbit_nxt = mem_q_r[start_r[BIT_W-1:0]];
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD_W{1'b0}}, used_r, res_qbit_r, res_first_r,
                            res_status_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q_r <= map_mem[rd_w_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      page_count_r <= PAGE_COUNT_RST;
      used_r       <= '0;
      rd_w_r       <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_count_r <= page_count_nxt;
      used_r       <= used_nxt;
      rd_w_r       <= rd_w_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    start_r      <= start_nxt;
    len_r        <= len_nxt;
    found_r      <= found_nxt;
    run_r        <= run_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    end_w_r      <= end_w_nxt;
    pend_w_r     <= pend_w_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_qbit_r   <= res_qbit_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: bench/tb.sv
// Testbench of the page bitmap allocator: directed and random commands checked against a bitmap model.
module tb;
  import pba_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int TOP_PAGES   = NUM_PAGES_DEF;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    pba_status_t       status;
    logic [PAGE_W-1:0] first_page;
    logic              page_is_used;
    logic [CNT_W-1:0]  used_count;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } live_run_t;

  class alloc_tracker;
    bit            page_used[TOP_PAGES];
    int unsigned   used_total = 0;
    int unsigned   active = TOP_PAGES;
    alloc_result_t pending[$];
    alloc_result_t last;
    int            failures = 0;
    int            reported = 0;
    int            results_seen = 0;
    int            commands_seen = 0;
    int            status_hits[3];

    function void set_page_count(logic [LEN_W-1:0] value);
      active = (value < TOP_PAGES) ? value : TOP_PAGES;
      used_total = 0;
      for (int p = 0; p < active; p++) used_total += page_used[p];
    endfunction

    function void note_command(pba_cmd_t cmd, logic [PAGE_W-1:0] start,
                               logic [LEN_W-1:0] len);
      alloc_result_t r;
      int unsigned   found;
      int unsigned   run;
      int unsigned   p;
      bit            ok;
      bit            set_bit;
      r.status       = STAT_OK;
      r.first_page   = '0;
      r.page_is_used = 1'b0;
      found          = 0;
      run            = 0;
      ok             = 0;
      set_bit        = (cmd == CMD_RESERVE);
      case (cmd)
        CMD_ALLOC: begin
          if (len != 0) begin
            for (p = 0; p < active; p++) begin
              if (!page_used[p]) begin
                if (found == 0) run = p;
                found++;
                if (found == len) begin
                  ok = (run < (1 << PAGE_W));
                  break;
                end
              end else begin
                found = 0;
              end
            end
          end
          if (ok) begin
            for (p = run; p < run + len; p++) page_used[p] = 1'b1;
            used_total += len;
            r.first_page = run[PAGE_W-1:0];
          end else begin
            r.status = STAT_NORUN;
          end
        end
        CMD_FREE, CMD_RESERVE: begin
          for (p = start; p < start + len && p < active; p++) begin
            if (page_used[p] != set_bit) begin
              page_used[p] = set_bit;
              if (set_bit) used_total++;
              else used_total--;
            end
          end
        end
        default: begin
          if (start >= active) r.status = STAT_RANGE;
          else r.page_is_used = page_used[start];
        end
      endcase
      r.used_count = used_total[CNT_W-1:0];
      pending.push_back(r);
      last = r;
      commands_seen++;
      status_hits[r.status]++;
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        failures++;
        if (reported < 10)
          $display("mismatch on %s at result %0d: expected %0h, got %0h",
                   name, results_seen, want, got);
        reported++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      alloc_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        failures++;
        if (reported < 10) $display("unexpected result %0d: %0h", results_seen, word);
        reported++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, word[1:0]);
      compare_field("first_page", want.first_page, word[17:2]);
      compare_field("page_is_used", want.page_is_used, word[18]);
      compare_field("used_count", want.used_count, word[35:19]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // start_page[15:0], run_pages[32:16]
  logic [CMD_W-1:0]       in_tuser = CMD_ALLOC;  // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, first_page, page_is_used, used_count
  logic                   cfg_wen = 1'b0;
  logic [LEN_W-1:0]       cfg_wdata = '0;

  alloc_tracker tracker = new();
  live_run_t    live_runs[$];
  bit           idle_on = 1'b1;
  bit           long_hold_req = 1'b0;
  int           settings_written = 0;
  int unsigned  phase_counts[8] = '{131071, 64, 1, 200, 37, 1000, 65536, 512};

  page_bitmap_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_word(pba_cmd_t cmd, logic [PAGE_W-1:0] start, logic [LEN_W-1:0] len);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {{(IN_TDATA_W - LEN_W - PAGE_W){1'b0}}, len, start};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(cmd, start, len);
  endtask

  task automatic drain(int settle);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_page_count(logic [LEN_W-1:0] value);
    drain(4);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    tracker.set_page_count(value);
    settings_written++;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic random_cmds(int n);
    int unsigned act;
    int unsigned start;
    int unsigned len;
    int unsigned sel;
    int unsigned k;
    pba_cmd_t    cmd;
    live_run_t   lr;
    for (int i = 0; i < n; i++) begin
      act   = tracker.active;
      sel   = $urandom_range(0, 99);
      start = (act > 0 && $urandom_range(0, 9) != 0) ?
              $urandom_range(0, (act > 65535) ? 65535 : act) : $urandom_range(0, 65535);
      k     = $urandom_range(0, 19);
      len   = (k == 0) ? $urandom_range(0, 131071) :
              (k <= 2) ? $urandom_range(0, act) : $urandom_range(0, 33);
      if (sel < 35) begin
        cmd = CMD_ALLOC;
      end else if (sel < 60) begin
        cmd = CMD_FREE;
        if (live_runs.size() != 0 && $urandom_range(0, 2) != 0) begin
          k = $urandom_range(0, live_runs.size() - 1);
          lr = live_runs[k];
          live_runs.delete(k);
          start = lr.first;
          len   = lr.len;
        end
      end else if (sel < 75) begin
        cmd = CMD_RESERVE;
      end else begin
        cmd = CMD_QUERY;
        if (live_runs.size() != 0 && $urandom_range(0, 1) != 0) begin
          lr = live_runs[$urandom_range(0, live_runs.size() - 1)];
          start = lr.first + $urandom_range(0, lr.len - 1);
        end
      end
      send_word(cmd, PAGE_W'(start), LEN_W'(len));
      if (cmd == CMD_ALLOC && tracker.last.status == STAT_OK)
        live_runs.push_back('{tracker.last.first_page, len});
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_word(CMD_QUERY, 0, 0);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_ALLOC, 0, 5);
    send_word(CMD_RESERVE, 10, 3);
    send_word(CMD_ALLOC, 0, 4);
    send_word(CMD_FREE, 2, 2);
    send_word(CMD_QUERY, 2, 0);
    send_word(CMD_QUERY, 11, 0);
    send_word(CMD_RESERVE, 16'hFFFA, 100);
    send_word(CMD_QUERY, 16'hFFFF, 0);
    send_word(CMD_FREE, 16'hFFFF, 17'h1FFFF);
    send_word(CMD_ALLOC, 0, 17'h10000);
    send_word(CMD_ALLOC, 0, 17'h1FFFF);
    send_word(CMD_FREE, 0, 17'h10000);
    send_word(CMD_ALLOC, 16'hFFFF, 17'h10000);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_QUERY, 16'hFFFF, 0);
    send_word(CMD_FREE, 0, 17'h10000);
    send_word(CMD_RESERVE, 100, 11);
    write_page_count(0);
    send_word(CMD_QUERY, 0, 0);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_RESERVE, 0, 5);
    write_page_count(64);
    send_word(CMD_QUERY, 64, 0);
    send_word(CMD_QUERY, 63, 0);

    foreach (phase_counts[i]) begin
      write_page_count(LEN_W'(phase_counts[i]));
      live_runs.delete();
      idle_on = (i != 7) && ($urandom_range(0, 3) != 0);
      if (i == 3) long_hold_req = 1'b1;
      random_cmds(33);
    end

    drain(20);
    $display("%0d commands over %0d page_count settings, %0d results checked",
             tracker.commands_seen, settings_written, tracker.results_seen);
    $display("status seen: %0d ok, %0d without a free run, %0d out of range",
             tracker.status_hits[STAT_OK], tracker.status_hits[STAT_NORUN],
             tracker.status_hits[STAT_RANGE]);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
